FILE: sv/qtbm_pkg.sv
package qtbm_pkg;

   // Codeword geometry
   localparam int SYMBOLS  = 16;
   localparam int BITS     = $clog2(SYMBOLS);
   localparam int DIST_N   = 2 * BITS;
   localparam int CNT_W    = BITS;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int LEVEL_W  = 16;
   localparam int DIFF_W   = 17;
   localparam int PROD_W   = 34;
   localparam int DIST_W   = 32;
   localparam int METRIC_W = 35;
   localparam int INDEX_W  = 6;
   localparam int POS_W    = 3;
   localparam int RSP_DATA_W = ((METRIC_W + INDEX_W + 7) / 8) * 8;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_REAL_ZERO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REAL_ONE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAG_ZERO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAG_ONE  = 2'd3;

   // Reset levels, +/- 0.7071 in Q3.12
   localparam logic signed [LEVEL_W-1:0] LEVEL_NEG_RESET = -16'sd2896;
   localparam logic signed [LEVEL_W-1:0] LEVEL_POS_RESET = 16'sd2896;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] real_zero;
      logic signed [LEVEL_W-1:0] real_one;
      logic signed [LEVEL_W-1:0] imag_zero;
      logic signed [LEVEL_W-1:0] imag_one;
   } levels_type;

   typedef logic [DIST_N-1:0][DIST_W-1:0] dist_array_type;

   // Bank load handoff from distance stage to metric emitter
   typedef struct packed {
      logic valid;
      logic mark;
   } load_type;

endpackage

FILE: sv/qtbm_csr.sv
module qtbm_csr
   import qtbm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [LEVEL_W-1:0]          csr_data,
   output levels_type                  levels
);

   levels_type levels_ff;
   levels_type levels_in;

   assign csr_ready = 1'b1;
   assign levels    = levels_ff;

   // Register write decode
   always_comb begin
      levels_in = levels_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_REAL_ZERO: levels_in.real_zero = csr_data;
            CSR_REAL_ONE:  levels_in.real_one  = csr_data;
            CSR_IMAG_ZERO: levels_in.imag_zero = csr_data;
            CSR_IMAG_ONE:  levels_in.imag_one  = csr_data;
            default:       levels_in = levels_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff.real_zero <= LEVEL_NEG_RESET;
         levels_ff.real_one  <= LEVEL_POS_RESET;
         levels_ff.imag_zero <= LEVEL_NEG_RESET;
         levels_ff.imag_one  <= LEVEL_POS_RESET;
      end else begin
         levels_ff <= levels_in;
      end
   end

endmodule

FILE: sv/qtbm_dist.sv
module qtbm_dist
   import qtbm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        req_new_packet,
   input  levels_type                  levels,
   input  logic                        bank_free,
   output load_type                    load,
   output dist_array_type              load_dist
);

   // Codeword tracking state
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              axis_ff, axis_in;
   logic              mark_ff, mark_in;

   // Input register
   logic                       in_valid_ff, in_valid_in;
   logic signed [SAMPLE_W-1:0] in_sample_ff, in_sample_in;
   logic [POS_W-1:0]           in_pos_ff, in_pos_in;
   logic                       in_axis_ff, in_axis_in;
   logic                       in_complete_ff, in_complete_in;
   logic                       in_mark_ff, in_mark_in;

   // Distance store, written one sample position at a time
   dist_array_type store_ff, store_in;

   logic              accept;
   logic              advance;
   logic [POS_W-1:0]  pos_cur;
   logic              axis_cur;
   logic              complete;
   logic signed [LEVEL_W-1:0] level0, level1;
   logic signed [DIFF_W-1:0]  diff0, diff1;
   logic signed [PROD_W-1:0]  prod0, prod1;

   // A completing sample waits in the input register until the bank frees up
   assign advance    = !in_valid_ff || !in_complete_ff || bank_free;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // Position and axis as seen by the arriving sample
   always_comb begin
      pos_cur  = req_new_packet ? '0 : pos_ff;
      axis_cur = req_new_packet ? 1'b0 : axis_ff;
      complete = (pos_cur == POS_W'(BITS - 1));
      pos_in   = pos_ff;
      axis_in  = axis_ff;
      mark_in  = mark_ff;
      if (accept) begin
         pos_in  = complete ? '0 : pos_cur + POS_W'(1);
         axis_in = ~axis_cur;
         if (pos_cur == '0) begin
            mark_in = req_new_packet;
         end
      end
   end

   // Input register load
   always_comb begin
      in_valid_in    = advance ? accept : in_valid_ff;
      in_sample_in   = in_sample_ff;
      in_pos_in      = in_pos_ff;
      in_axis_in     = in_axis_ff;
      in_complete_in = in_complete_ff;
      in_mark_in     = in_mark_ff;
      if (accept) begin
         in_sample_in   = req_sample;
         in_pos_in      = pos_cur;
         in_axis_in     = axis_cur;
         in_complete_in = complete;
         in_mark_in     = mark_in;
      end
   end

   // Squared distances to both levels of the sample's axis
   always_comb begin
      level0 = in_axis_ff ? levels.imag_zero : levels.real_zero;
      level1 = in_axis_ff ? levels.imag_one  : levels.real_one;
      diff0  = DIFF_W'(level0) - DIFF_W'(in_sample_ff);
      diff1  = DIFF_W'(level1) - DIFF_W'(in_sample_ff);
      prod0  = diff0 * diff0;
      prod1  = diff1 * diff1;
   end

   // Store write; the bank copy sees this cycle's write as well
   always_comb begin
      store_in = store_ff;
      if (in_valid_ff && advance) begin
         for (int e = 0; e < BITS; e++) begin
            if (in_pos_ff == POS_W'(e)) begin
               store_in[2*e]     = prod0[DIST_W-1:0];
               store_in[2*e + 1] = prod1[DIST_W-1:0];
            end
         end
      end
   end

   assign load_dist  = store_in;
   assign load.valid = in_valid_ff && in_complete_ff && bank_free;
   assign load.mark  = in_mark_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         axis_ff     <= 1'b0;
         mark_ff     <= 1'b0;
         in_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         axis_ff     <= axis_in;
         mark_ff     <= mark_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_sample_ff   <= in_sample_in;
      in_pos_ff      <= in_pos_in;
      in_axis_ff     <= in_axis_in;
      in_complete_ff <= in_complete_in;
      in_mark_ff     <= in_mark_in;
      store_ff       <= store_in;
   end

   // A stalled completing sample stays put
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_complete_ff && !bank_free |=> in_valid_ff && in_complete_ff)
      else $error("completing sample lost while bank busy");

   // Position never reaches a full codeword
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < POS_W'(BITS))
      else $error("sample position out of range");

endmodule

FILE: sv/qtbm_emit.sv
module qtbm_emit
   import qtbm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  load_type                    load,
   input  dist_array_type              load_dist,
   output logic                        bank_free,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [METRIC_W-1:0]         rsp_metric,
   output logic [INDEX_W-1:0]          rsp_symbol_index,
   output logic                        rsp_packet_start,
   output logic                        rsp_last
);

   // Metric bank and symbol counter
   dist_array_type    bank_ff, bank_in;
   logic              bank_mark_ff, bank_mark_in;
   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [METRIC_W-1:0]   metric_ff, metric_in;
   logic [INDEX_W-1:0]    index_ff, index_in;
   logic                  pstart_ff, pstart_in;
   logic                  last_ff, last_in;

   logic                  out_load;
   logic                  cnt_last;
   logic [METRIC_W-1:0]   sum;

   assign cnt_last  = (cnt_ff == CNT_W'(SYMBOLS - 1));
   assign out_load  = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign bank_free = !busy_ff || (out_load && cnt_last);

   // Metric: one distance per codeword bit, picked by that bit of the symbol
   always_comb begin
      sum = '0;
      for (int k = 0; k < BITS; k++) begin
         sum = sum + METRIC_W'(cnt_ff[k] ? bank_ff[2*k + 1] : bank_ff[2*k]);
      end
   end

   // Bank and counter
   always_comb begin
      bank_in      = bank_ff;
      bank_mark_in = bank_mark_ff;
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      if (load.valid) begin
         bank_in      = load_dist;
         bank_mark_in = load.mark;
         busy_in      = 1'b1;
         cnt_in       = '0;
      end else if (out_load) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_last) begin
            busy_in = 1'b0;
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      metric_in    = metric_ff;
      index_in     = index_ff;
      pstart_in    = pstart_ff;
      last_in      = last_ff;
      if (out_load) begin
         metric_in = sum;
         index_in  = INDEX_W'(cnt_ff);
         pstart_in = (cnt_ff == '0) && bank_mark_ff;
         last_in   = cnt_last;
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_metric       = metric_ff;
   assign rsp_symbol_index = index_ff;
   assign rsp_packet_start = pstart_ff;
   assign rsp_last         = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff      <= bank_in;
      bank_mark_ff <= bank_mark_in;
      metric_ff    <= metric_in;
      index_ff     <= index_in;
      pstart_ff    <= pstart_in;
      last_ff      <= last_in;
   end

   // The bank never gets overwritten mid-run
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load.valid |-> !busy_ff || (out_load && cnt_last))
      else $error("bank loaded while still emitting");

   // A run always starts at symbol zero
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> cnt_ff == '0)
      else $error("run started at nonzero symbol");

   // Packet marker only on the first symbol
   a_pstart_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && pstart_ff |-> index_ff == '0)
      else $error("packet start on nonzero symbol");

   // Emitter idles after its last symbol unless reloaded
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      out_load && cnt_last && !load.valid |=> !busy_ff)
      else $error("emitter kept running past last symbol");

endmodule

FILE: sv/qpsk_trellis_branch_metrics.sv
// Flow: a request's squared distances are written to the distance store from the input register;
//   a completing request loads the metric bank once free; metric 0 then enters the result register.
// Throughput: one request per cycle while a codeword fills; each codeword of BITS requests yields
//   SYMBOLS metrics, one per cycle from the result register while rsp_tready is high.
// Reset (synchronous, active high): levels return to -/+2896, a fresh codeword starts on the
//   real axis, no result is pending; the distance store is not cleared.
module qpsk_trellis_branch_metrics
   import qtbm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [SAMPLE_W-1:0]     req_tdata,   // [15:0] sample
   input  logic                    req_tuser,   // [0] new_packet
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // [34:0] metric, [40:35] symbol_index, rest zero
   output logic                    rsp_tuser,   // [0] packet_start
   output logic                    rsp_tlast,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [LEVEL_W-1:0]      csr_data
);

   levels_type       levels;
   load_type         load;
   dist_array_type   load_dist;
   logic             bank_free;
   logic [METRIC_W-1:0] metric;
   logic [INDEX_W-1:0]  symbol_index;

   qtbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .levels    (levels)
   );

   qtbm_dist u_dist (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_sample     (req_tdata),
      .req_new_packet (req_tuser),
      .levels         (levels),
      .bank_free      (bank_free),
      .load           (load),
      .load_dist      (load_dist)
   );

   qtbm_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .load_dist        (load_dist),
      .bank_free        (bank_free),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_metric       (metric),
      .rsp_symbol_index (symbol_index),
      .rsp_packet_start (rsp_tuser),
      .rsp_last         (rsp_tlast)
   );

   // Pack result fields, metric in the low bits
   assign rsp_tdata = {{(RSP_DATA_W - METRIC_W - INDEX_W){1'b0}}, symbol_index, metric};

endmodule
